@@ rtl/core/mf3x3_pkg.sv @@
package mf3x3_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 512;
   localparam int PIXEL_BITS_DEFAULT = 8;
   localparam int MAX_HEIGHT         = 512;
   localparam int MIN_SIZE           = 3;
   localparam int RESET_SIZE         = 512;

   localparam int CSR_DATA_BITS  = 10;
   localparam int CSR_INDEX_BITS = 1;
   localparam int HEIGHT_BITS    = 10;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type REG_IMAGE_WIDTH  = 1'b0;
   localparam csr_index_type REG_IMAGE_HEIGHT = 1'b1;

endpackage

@@ rtl/core/median_filter_3x3_inplace.sv @@
// channel   direction  handshake                 payload
// req       in         req_valid / req_stall     req_drain, req_pixel_in
// rsp       out        rsp_valid / rsp_stall     rsp_pixel_out, rsp_frame_end
// csr       in         csr_write                 csr_index, csr_wdata
//
// one transaction per cycle sustained while req_stall is low; a result passes
// from its transaction through the line store read stage, then the output register.
// the 9-input median network sits between the line store read data and the
// output register. reset is synchronous and clears counters, window and valid
// flags; the two line stores are not cleared and need no clearing pass.
// req_stall rises only while the read stage holds a result and rsp is stalled.
module median_filter_3x3_inplace #(
   parameter int MAX_WIDTH  = mf3x3_pkg::MAX_WIDTH_DEFAULT,
   parameter int PIXEL_BITS = mf3x3_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_drain,
   input  logic [PIXEL_BITS-1:0]              req_pixel_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [PIXEL_BITS-1:0]              rsp_pixel_out,
   output logic                               rsp_frame_end,
   input  logic                               csr_write,
   input  mf3x3_pkg::csr_index_type           csr_index,
   input  logic [mf3x3_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int WW        = $clog2(MAX_WIDTH + 1);
   localparam int CW        = $clog2(MAX_WIDTH);
   localparam int RAW_DEPTH = MAX_WIDTH + 2;
   localparam int PW        = $clog2(RAW_DEPTH);
   localparam int HB        = mf3x3_pkg::HEIGHT_BITS;
   localparam int RB        = $clog2(mf3x3_pkg::MAX_HEIGHT);
   localparam int TW        = $clog2(MAX_WIDTH * mf3x3_pkg::MAX_HEIGHT + 1);
   localparam int RESET_W   = (mf3x3_pkg::RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH
                                                                  : mf3x3_pkg::RESET_SIZE;
   localparam int RESET_H   = mf3x3_pkg::RESET_SIZE;

   // configuration
   logic [WW-1:0] width_ff, width_in;
   logic [HB-1:0] height_ff, height_in;
   logic [TW-1:0] total_ff, total_in;

   // frame counters
   logic [TW-1:0] recv_ff, recv_in;
   logic [TW-1:0] emit_cnt_ff, emit_cnt_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RB-1:0] row_ff, row_in;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0] lead_ff, lead_in;

   // read stage
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_border_ff, s1_border_in;
   logic                  s1_last_ff, s1_last_in;
   logic [CW-1:0]         s1_col_ff, s1_col_in;
   logic [PIXEL_BITS-1:0] s1_bottom_ff, s1_bottom_in;

   // window columns kept from the previous result
   logic [PIXEL_BITS-1:0] tc_ff, tc_in;
   logic [PIXEL_BITS-1:0] tr_ff, tr_in;
   logic [PIXEL_BITS-1:0] mr_ff, mr_in;
   logic [PIXEL_BITS-1:0] bc_ff, bc_in;
   logic [PIXEL_BITS-1:0] br_ff, br_in;
   logic [PIXEL_BITS-1:0] left_ff, left_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_BITS-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept, take_pixel, do_emit, retire, advance, frame_last;
   logic [WW-1:0]         csr_w_eff;
   logic [HB-1:0]         csr_h_eff;
   logic [CW-1:0]         col_last;
   logic [RB-1:0]         row_last;
   logic [PW-1:0]         ptr_last;

   logic                  raw_wr_en;
   logic [PIXEL_BITS-1:0] raw_rd_data;
   logic [CW-1:0]         above_rd_addr;
   logic [PIXEL_BITS-1:0] above_rd_data;
   logic [PIXEL_BITS-1:0] median, result;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign retire    = s1_valid_ff && advance;

   assign col_last = CW'(width_ff - WW'(1));
   assign row_last = RB'(height_ff - HB'(1));
   assign ptr_last = PW'(width_ff + WW'(1));

   assign take_pixel = !req_drain && (recv_ff < total_ff);
   assign do_emit    = accept && (take_pixel ? (lead_ff == ptr_last) : (recv_ff == total_ff));
   assign frame_last = (emit_cnt_ff == TW'(total_ff - TW'(1)));
   assign raw_wr_en  = accept && take_pixel;

   assign above_rd_addr = (col_ff == col_last) ? '0 : CW'(col_ff + CW'(1));

   always_comb begin
      if (csr_wdata < mf3x3_pkg::CSR_DATA_BITS'(mf3x3_pkg::MIN_SIZE)) begin
         csr_w_eff = WW'(mf3x3_pkg::MIN_SIZE);
         csr_h_eff = HB'(mf3x3_pkg::MIN_SIZE);
      end else begin
         if (32'(csr_wdata) > MAX_WIDTH) begin
            csr_w_eff = WW'(MAX_WIDTH);
         end else begin
            csr_w_eff = WW'(csr_wdata);
         end
         if (32'(csr_wdata) > mf3x3_pkg::MAX_HEIGHT) begin
            csr_h_eff = HB'(mf3x3_pkg::MAX_HEIGHT);
         end else begin
            csr_h_eff = HB'(csr_wdata);
         end
      end
   end

   // frame control
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      total_in     = total_ff;
      recv_in      = recv_ff;
      emit_cnt_in  = emit_cnt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      lead_in      = lead_ff;
      s1_border_in = s1_border_ff;
      s1_last_in   = s1_last_ff;
      s1_col_in    = s1_col_ff;
      s1_bottom_in = s1_bottom_ff;

      if (accept && take_pixel) begin
         recv_in   = TW'(recv_ff + TW'(1));
         wr_ptr_in = (wr_ptr_ff == ptr_last) ? '0 : PW'(wr_ptr_ff + PW'(1));
         if (!do_emit) begin
            lead_in = PW'(lead_ff + PW'(1));
         end
      end

      if (do_emit) begin
         s1_border_in = (row_ff == '0) || (row_ff == row_last) ||
                        (col_ff == '0) || (col_ff == col_last);
         s1_last_in   = frame_last;
         s1_col_in    = col_ff;
         s1_bottom_in = req_pixel_in;
         emit_cnt_in  = TW'(emit_cnt_ff + TW'(1));
         rd_ptr_in    = (rd_ptr_ff == ptr_last) ? '0 : PW'(rd_ptr_ff + PW'(1));
         if (col_ff == col_last) begin
            col_in = '0;
            row_in = RB'(row_ff + RB'(1));
         end else begin
            col_in = CW'(col_ff + CW'(1));
         end
      end

      if (csr_write) begin
         unique case (csr_index)
            mf3x3_pkg::REG_IMAGE_WIDTH: begin
               width_in = csr_w_eff;
            end
            mf3x3_pkg::REG_IMAGE_HEIGHT: begin
               height_in = csr_h_eff;
            end
            default: begin
            end
         endcase
         total_in = TW'(TW'(width_in) * TW'(height_in));
      end

      if (csr_write || (do_emit && frame_last)) begin
         recv_in     = '0;
         emit_cnt_in = '0;
         col_in      = '0;
         row_in      = '0;
         wr_ptr_in   = '0;
         rd_ptr_in   = PW'(1);
         lead_in     = '0;
      end
   end

   // median network
   always_comb begin
      logic [PIXEL_BITS-1:0] p [9];
      logic [PIXEL_BITS-1:0] t;
      p[0] = tc_ff;
      p[1] = tr_ff;
      p[2] = above_rd_data;
      p[3] = left_ff;
      p[4] = mr_ff;
      p[5] = raw_rd_data;
      p[6] = bc_ff;
      p[7] = br_ff;
      p[8] = s1_bottom_ff;
      t    = '0;
      if (p[1] > p[2]) begin t = p[1]; p[1] = p[2]; p[2] = t; end
      if (p[4] > p[5]) begin t = p[4]; p[4] = p[5]; p[5] = t; end
      if (p[7] > p[8]) begin t = p[7]; p[7] = p[8]; p[8] = t; end
      if (p[0] > p[1]) begin t = p[0]; p[0] = p[1]; p[1] = t; end
      if (p[3] > p[4]) begin t = p[3]; p[3] = p[4]; p[4] = t; end
      if (p[6] > p[7]) begin t = p[6]; p[6] = p[7]; p[7] = t; end
      if (p[1] > p[2]) begin t = p[1]; p[1] = p[2]; p[2] = t; end
      if (p[4] > p[5]) begin t = p[4]; p[4] = p[5]; p[5] = t; end
      if (p[7] > p[8]) begin t = p[7]; p[7] = p[8]; p[8] = t; end
      if (p[0] > p[3]) begin t = p[0]; p[0] = p[3]; p[3] = t; end
      if (p[5] > p[8]) begin t = p[5]; p[5] = p[8]; p[8] = t; end
      if (p[4] > p[7]) begin t = p[4]; p[4] = p[7]; p[7] = t; end
      if (p[3] > p[6]) begin t = p[3]; p[3] = p[6]; p[6] = t; end
      if (p[1] > p[4]) begin t = p[1]; p[1] = p[4]; p[4] = t; end
      if (p[2] > p[5]) begin t = p[2]; p[2] = p[5]; p[5] = t; end
      if (p[4] > p[7]) begin t = p[4]; p[4] = p[7]; p[7] = t; end
      if (p[4] > p[2]) begin t = p[4]; p[4] = p[2]; p[2] = t; end
      if (p[6] > p[4]) begin t = p[6]; p[6] = p[4]; p[4] = t; end
      if (p[4] > p[2]) begin t = p[4]; p[4] = p[2]; p[2] = t; end
      median = p[4];
   end

   assign result = s1_border_ff ? mr_ff : median;

   // window shift, output register
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      tc_in        = tc_ff;
      tr_in        = tr_ff;
      mr_in        = mr_ff;
      bc_in        = bc_ff;
      br_in        = br_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_last_in  = rsp_last_ff;

      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end
      if (do_emit) begin
         s1_valid_in = 1'b1;
      end

      if (retire) begin
         tc_in        = tr_ff;
         tr_in        = above_rd_data;
         mr_in        = raw_rd_data;
         bc_in        = br_ff;
         br_in        = s1_bottom_ff;
         left_in      = result;
         rsp_pixel_in = result;
         rsp_last_in  = s1_last_ff;
      end

      // first pixel of a frame primes the centre of the window
      if (accept && take_pixel && (recv_ff == '0)) begin
         mr_in = req_pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WW'(RESET_W);
         height_ff    <= HB'(RESET_H);
         total_ff     <= TW'(RESET_W * RESET_H);
         recv_ff      <= '0;
         emit_cnt_ff  <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= PW'(1);
         lead_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tc_ff        <= '0;
         tr_ff        <= '0;
         mr_ff        <= '0;
         bc_ff        <= '0;
         br_ff        <= '0;
         left_ff      <= '0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         total_ff     <= total_in;
         recv_ff      <= recv_in;
         emit_cnt_ff  <= emit_cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         lead_ff      <= lead_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         tc_ff        <= tc_in;
         tr_ff        <= tr_in;
         mr_ff        <= mr_in;
         bc_ff        <= bc_in;
         br_ff        <= br_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_border_ff <= s1_border_in;
      s1_last_ff   <= s1_last_in;
      s1_col_ff    <= s1_col_in;
      s1_bottom_ff <= s1_bottom_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // raw pixel ring, one line plus two
   mf3x3_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (RAW_DEPTH)
   ) u_raw_ram (
      .clock   (clock),
      .wr_en   (raw_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_pixel_in),
      .rd_en   (do_emit),
      .rd_addr (rd_ptr_ff),
      .rd_data (raw_rd_data)
   );

   // filtered line, column indexed
   mf3x3_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_above_ram (
      .clock   (clock),
      .wr_en   (retire),
      .wr_addr (s1_col_ff),
      .wr_data (result),
      .rd_en   (do_emit),
      .rd_addr (above_rd_addr),
      .rd_data (above_rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_frame_end = rsp_last_ff;

endmodule

@@ rtl/core/mf3x3_ram.sv @@
module mf3x3_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 512,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
